FILE: hdl/sobo_pkg.sv
// Shared types and constants for the sphere versus oriented box overlap block.
package sobo_pkg;

    localparam int CoordW = 32;
    localparam int RadW   = 31;
    localparam int QuatW  = 16;
    localparam int QFrac  = 14;
    localparam int CfgIdxW = 3;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] RegMinX = 3'd0;
    localparam logic [CfgIdxW-1:0] RegMinY = 3'd1;
    localparam logic [CfgIdxW-1:0] RegMinZ = 3'd2;
    localparam logic [CfgIdxW-1:0] RegMaxX = 3'd3;
    localparam logic [CfgIdxW-1:0] RegMaxY = 3'd4;
    localparam logic [CfgIdxW-1:0] RegMaxZ = 3'd5;

    // Input tdata layout, first field in the lowest bits.
    localparam int InW = 3 * CoordW + RadW + 3 * CoordW + 4 * QuatW;  // 287
    localparam int InBytesW = ((InW + 7) / 8) * 8;                     // 288

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [CoordW:0]   diff_t;   // exact 33-bit difference
    typedef logic signed [17:0]       elem_t;   // rounded Q.14 element, |e| up to 2^16
    typedef logic signed [50:0]       prod_t;   // diff times element
    typedef logic signed [52:0]       acc_t;    // three products summed
    typedef logic signed [39:0]       loc_t;    // rounded local coordinate
    typedef logic [40:0]              dist_t;   // absolute clamp distance
    typedef logic [63:0]              sq_t;

endpackage

FILE: hdl/sphere_oriented_box_overlap.sv
// Top level of the sphere versus oriented box overlap pipeline.
//
//  Channel  | Direction | Handshake              | Payload
//  s_       | in        | s_tvalid / s_tready    | s_tdata: query fields
//  m_       | out       | m_tvalid / m_tready    | m_tdata[0]: hit
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One query enters per cycle while no stall on m_tready holds the pipeline.
// Seven register stages: differences and quaternion products, matrix elements,
// element products, row sums with rounding, clamp, far-axis check and squares, sum and compare.
// aresetn (synchronous) clears all stage valid bits and the bound registers.
// A stall on m_tready freezes the whole pipeline; nothing is lost or repeated.
module sphere_oriented_box_overlap (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sphere_x, sphere_y, sphere_z, sphere_radius, box_pos_x, box_pos_y,
    // box_pos_z, rot_x, rot_y, rot_z, rot_w, then one zero pad bit
    input  logic [sobo_pkg::InBytesW-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit, then seven zero pad bits
    output logic [7:0]                    m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sobo_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [sobo_pkg::CoordW-1:0]   cfg_data
);

    localparam int NStg = 7;

    // Field unpacking.
    sobo_pkg::coord_t sx, sy, sz, px, py, pz;
    logic [sobo_pkg::RadW-1:0] rad;
    logic signed [15:0] qx, qy, qz, qw;
    assign sx  = s_tdata[31:0];
    assign sy  = s_tdata[63:32];
    assign sz  = s_tdata[95:64];
    assign rad = s_tdata[126:96];
    assign px  = s_tdata[158:127];
    assign py  = s_tdata[190:159];
    assign pz  = s_tdata[222:191];
    assign qx  = s_tdata[238:223];
    assign qy  = s_tdata[254:239];
    assign qz  = s_tdata[270:255];
    assign qw  = s_tdata[286:271];

    // Pipeline advances whenever the output slot is free or being taken.
    logic adv;
    logic [NStg-1:0] vld_reg;
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = vld_reg[NStg-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NStg-2:0], s_tvalid};
        end
    end

    // Configuration registers.
    sobo_pkg::coord_t lo_reg [3];
    sobo_pkg::coord_t hi_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg <= '{default: '0};
            hi_reg <= '{default: '0};
        end else if (cfg_valid) begin
            case (cfg_index)
                sobo_pkg::RegMinX: lo_reg[0] <= cfg_data;
                sobo_pkg::RegMinY: lo_reg[1] <= cfg_data;
                sobo_pkg::RegMinZ: lo_reg[2] <= cfg_data;
                sobo_pkg::RegMaxX: hi_reg[0] <= cfg_data;
                sobo_pkg::RegMaxY: hi_reg[1] <= cfg_data;
                sobo_pkg::RegMaxZ: hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: differences and quaternion products (Q.28).
    sobo_pkg::diff_t d1_reg [3];
    logic [sobo_pkg::RadW-1:0] r1_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [31:0] xw_reg, yw_reg, zw_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg[0] <= 33'(sx) - 33'(px);
            d1_reg[1] <= 33'(sy) - 33'(py);
            d1_reg[2] <= 33'(sz) - 33'(pz);
            r1_reg <= rad;
            xx_reg <= qx * qx; yy_reg <= qy * qy; zz_reg <= qz * qz;
            xy_reg <= qx * qy; xz_reg <= qx * qz; yz_reg <= qy * qz;
            xw_reg <= qx * qw; yw_reg <= qy * qw; zw_reg <= qz * qw;
        end
    end

    // Stage 2: matrix elements rounded half up to Q.14.
    function automatic sobo_pkg::elem_t rnd_e(input logic signed [35:0] e);
        logic signed [35:0] t;
        t = e + 36'sd8192;
        return 18'(t >>> sobo_pkg::QFrac);
    endfunction

    localparam logic signed [35:0] One = 36'sd1 << 28;
    sobo_pkg::elem_t m2_reg [3][3];
    sobo_pkg::diff_t d2_reg [3];
    logic [sobo_pkg::RadW-1:0] r2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_reg[0][0] <= rnd_e(One - 2 * (36'(yy_reg) + 36'(zz_reg)));
            m2_reg[0][1] <= rnd_e(2 * (36'(xy_reg) + 36'(zw_reg)));
            m2_reg[0][2] <= rnd_e(2 * (36'(xz_reg) - 36'(yw_reg)));
            m2_reg[1][0] <= rnd_e(2 * (36'(xy_reg) - 36'(zw_reg)));
            m2_reg[1][1] <= rnd_e(One - 2 * (36'(xx_reg) + 36'(zz_reg)));
            m2_reg[1][2] <= rnd_e(2 * (36'(yz_reg) + 36'(xw_reg)));
            m2_reg[2][0] <= rnd_e(2 * (36'(xz_reg) + 36'(yw_reg)));
            m2_reg[2][1] <= rnd_e(2 * (36'(yz_reg) - 36'(xw_reg)));
            m2_reg[2][2] <= rnd_e(One - 2 * (36'(xx_reg) + 36'(yy_reg)));
            d2_reg <= d1_reg;
            r2_reg <= r1_reg;
        end
    end

    // Stage 3: nine element products.
    sobo_pkg::prod_t p3_reg [3][3];
    logic [sobo_pkg::RadW-1:0] r3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p3_reg[i][j] <= 51'(d2_reg[j]) * 51'(m2_reg[i][j]);
                end
            end
            r3_reg <= r2_reg;
        end
    end

    // Stage 4: row sums, rounded to the coordinate format.
    sobo_pkg::loc_t l4_reg [3];
    logic [sobo_pkg::RadW-1:0] r4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                l4_reg[i] <= 40'((53'(p3_reg[i][0]) + 53'(p3_reg[i][1])
                                  + 53'(p3_reg[i][2]) + 53'sd8192) >>> sobo_pkg::QFrac);
            end
            r4_reg <= r3_reg;
        end
    end

    // Stage 5: clamp and absolute distance per axis.
    sobo_pkg::dist_t a5_reg [3];
    logic [sobo_pkg::RadW-1:0] r5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (l4_reg[i] < 40'(lo_reg[i]) && !(40'(lo_reg[i]) > 40'(hi_reg[i]))) begin
                    a5_reg[i] <= 41'(40'(lo_reg[i]) - l4_reg[i]);
                end else if (40'(lo_reg[i]) > 40'(hi_reg[i])) begin
                    a5_reg[i] <= (l4_reg[i] > 40'(lo_reg[i])) ?
                        41'(l4_reg[i] - 40'(lo_reg[i])) : 41'(40'(lo_reg[i]) - l4_reg[i]);
                end else if (l4_reg[i] > 40'(hi_reg[i])) begin
                    a5_reg[i] <= 41'(l4_reg[i] - 40'(hi_reg[i]));
                end else begin
                    a5_reg[i] <= '0;
                end
            end
            r5_reg <= r4_reg;
        end
    end

    // Stage 6: far-axis check and squares (each distance below 2^31 when kept).
    logic [61:0] s6_reg [3];
    logic        far6_reg;
    logic [61:0] rr6_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            far6_reg <= (a5_reg[0] > 41'(r5_reg)) || (a5_reg[1] > 41'(r5_reg))
                        || (a5_reg[2] > 41'(r5_reg));
            for (int i = 0; i < 3; i++) begin
                s6_reg[i] <= a5_reg[i][30:0] * a5_reg[i][30:0];
            end
            rr6_reg <= r5_reg * r5_reg;
        end
    end

    // Stage 7: sum and compare.
    logic hit7_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            hit7_reg <= !far6_reg &&
                ((64'(s6_reg[0]) + 64'(s6_reg[1]) + 64'(s6_reg[2])) <= 64'(rr6_reg));
        end
    end

    assign m_tdata = {7'b0, hit7_reg};

endmodule

FILE: tb/sphere_oriented_box_overlap_tb.sv
// Self-checking testbench for the sphere versus oriented box overlap pipeline.
module sphere_oriented_box_overlap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the last bound register; writes to them are ignored.
    localparam logic [sobo_pkg::CfgIdxW-1:0] RegSpare0 = 3'd6;
    localparam logic [sobo_pkg::CfgIdxW-1:0] RegSpare1 = 3'd7;

    // Query fields in transfer order.
    typedef struct {
        logic signed [31:0] sx, sy, sz;
        logic [30:0]        rad;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] qx, qy, qz, qw;
    } query_t;

    // Directed row: a query, plus a typed-in answer where it is obvious.
    typedef struct {
        query_t q;
        bit     known;
        bit     hit;
    } row_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [sobo_pkg::InBytesW-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [sobo_pkg::CfgIdxW-1:0]    cfg_index = '0;
    logic [sobo_pkg::CoordW-1:0]     cfg_data = '0;

    sphere_oriented_box_overlap u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock with a 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    longint bound_lo[3];
    longint bound_hi[3];
    bit     hit_queue[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_off = 1'b0;

    // Round half up from Q.14 to the coordinate format.
    function automatic longint round_q14(longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    // Predict the hit flag of one query against the current bounds.
    function automatic bit predict_hit(query_t q);
        longint d[3], loc[3], m[3][3];
        longint x, y, z, w, one, acc, p, diff, r;
        longint unsigned sum;
        x = q.qx; y = q.qy; z = q.qz; w = q.qw;
        one = 64'sd1 << 28;
        d[0] = longint'(q.sx) - longint'(q.px);
        d[1] = longint'(q.sy) - longint'(q.py);
        d[2] = longint'(q.sz) - longint'(q.pz);
        r = longint'({1'b0, q.rad});
        m[0][0] = one - 2 * (y*y + z*z);
        m[0][1] = 2 * (x*y + z*w);
        m[0][2] = 2 * (x*z - y*w);
        m[1][0] = 2 * (x*y - z*w);
        m[1][1] = one - 2 * (x*x + z*z);
        m[1][2] = 2 * (y*z + x*w);
        m[2][0] = 2 * (x*z + y*w);
        m[2][1] = 2 * (y*z - x*w);
        m[2][2] = one - 2 * (x*x + y*y);
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) acc += d[j] * round_q14(m[i][j]);
            loc[i] = round_q14(acc);
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            p = loc[i];
            if (p > bound_hi[i]) p = bound_hi[i];
            if (p < bound_lo[i]) p = bound_lo[i];
            diff = p - loc[i];
            if (diff < 0) diff = -diff;
            if (diff > r) return 1'b0;
            sum += longint'(diff * diff);
        end
        return (sum <= longint'(r * r));
    endfunction

    function automatic query_t random_query();
        query_t q;
        int mode;
        mode = $urandom_range(0, 3);
        q.sx = $urandom; q.sy = $urandom; q.sz = $urandom; q.rad = $urandom;
        q.px = $urandom; q.py = $urandom; q.pz = $urandom;
        q.qx = $urandom_range(0, 32768) - 16384;
        q.qy = $urandom_range(0, 32768) - 16384;
        q.qz = $urandom_range(0, 32768) - 16384;
        q.qw = $urandom_range(0, 32768) - 16384;
        if (mode != 0) begin
            // Near-box geometry so that both outcomes are common.
            q.sx = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            q.sy = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            q.sz = $signed($urandom_range(0, 32'h000C_0000)) - 32'sh0006_0000;
            q.px = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            q.py = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            q.pz = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            q.rad = $urandom_range(0, 32'h0004_0000);
        end
        if (mode == 2) begin
            // Roughly unit quaternion: one axis alone, or z and w equal.
            q.qx = 0; q.qy = 0; q.qz = 0; q.qw = 0;
            case ($urandom_range(0, 3))
                0: q.qw = $urandom_range(0, 1) ? 16384 : -16384;
                1: q.qx = 16384;
                2: q.qy = -16384;
                default: begin q.qz = 11585; q.qw = 11585; end
            endcase
        end
        return q;
    endfunction

    function automatic query_t make_query(int sx, int sy, int sz, int rad,
                                          int px, int py, int pz,
                                          int qx, int qy, int qz, int qw);
        query_t q;
        q.sx = sx; q.sy = sy; q.sz = sz; q.rad = rad;
        q.px = px; q.py = py; q.pz = pz;
        q.qx = qx; q.qy = qy; q.qz = qz; q.qw = qw;
        return q;
    endfunction

    // One register write transfer, mirrored into the predictor.
    task automatic write_reg(logic [sobo_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx < 3) bound_lo[idx] = longint'($signed(val));
        else if (idx < 6) bound_hi[idx - 3] = longint'($signed(val));
    endtask

    task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz);
        write_reg(sobo_pkg::RegMinX, lx);
        write_reg(sobo_pkg::RegMinY, ly);
        write_reg(sobo_pkg::RegMinZ, lz);
        write_reg(sobo_pkg::RegMaxX, hx);
        write_reg(sobo_pkg::RegMaxY, hy);
        write_reg(sobo_pkg::RegMaxZ, hz);
    endtask

    // One query transfer, with optional random idle cycles first.
    task automatic send_query(query_t q, bit known, bit hit);
        bit exp_hit;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        exp_hit = predict_hit(q);
        if (known && exp_hit != hit) begin
            $display("%0t: directed row disagrees: typed %0d predicted %0d",
                     $time, hit, exp_hit);
            errors++;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, q.qw, q.qz, q.qy, q.qx, q.pz, q.py, q.px,
                     q.rad, q.sz, q.sy, q.sx};
        do @(posedge aclk); while (!s_tready);
        hit_queue.push_back(known ? hit : exp_hit);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (hit_queue.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) send_query(random_query(), 1'b0, 1'b0);
    endtask

    // Receiver: random stalls plus a long hold-off on request.
    always @(posedge aclk) begin
        m_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_queue.size() == 0) begin
                $display("%0t: unexpected result hit=%0d", $time, m_tdata[0]);
                errors++;
            end else begin
                if (m_tdata[0] !== hit_queue[0]) begin
                    $display("%0t: hit mismatch: expected %0d actual %0d",
                             $time, hit_queue[0], m_tdata[0]);
                    errors++;
                end
                void'(hit_queue.pop_front());
            end
        end
    end

    // Watchdog.
    initial begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    row_t rows[$];

    initial begin
        for (int i = 0; i < 3; i++) begin bound_lo[i] = 0; bound_hi[i] = 0; end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed rows against the reset box, a single point at the origin.
        rows.push_back('{make_query(0,0,0,0, 0,0,0, 0,0,0,16384), 1, 1});
        rows.push_back('{make_query(65536,0,0,0, 0,0,0, 0,0,0,16384), 1, 0});
        rows.push_back('{make_query(65536,0,0,65536, 0,0,0, 0,0,0,16384), 1, 1});
        rows.push_back('{make_query(65536,0,0,65535, 0,0,0, 0,0,0,16384), 1, 0});
        rows.push_back('{make_query(32'h7FFFFFFF,0,0,32'h7FFFFFFF,
                                    32'h80000000,0,0, 0,0,0,16384), 1, 0});
        rows.push_back('{make_query(32'h80000000,32'h80000000,32'h80000000,
                                    32'h7FFFFFFF, 32'h7FFFFFFF,32'h7FFFFFFF,
                                    32'h7FFFFFFF, -16384,-16384,-16384,-16384),
                         0, 0});
        rows.push_back('{make_query(100,200,300,1000, 0,0,0, 0,0,0,0), 0, 0});
        rows.push_back('{make_query(100,200,300,1000, 0,0,0,
                                    16384,16384,16384,16384), 0, 0});
        rows.push_back('{make_query(5000,-7000,9000,40000, 1,2,3,
                                    16384,0,0,0), 0, 0});
        rows.push_back('{make_query(0,0,0,32'h7FFFFFFF, 0,0,0, 0,0,0,16384), 1, 1});
        foreach (rows[i]) send_query(rows[i].q, rows[i].known, rows[i].hit);
        drain();

        // Unit box with rotations, and an inverted axis.
        set_box(-65536, -65536, -65536, 65536, 65536, 65536);
        send_query(make_query(0,0,0,0, 0,0,0, 0,0,0,16384), 1, 1);
        send_query(make_query(200000,0,0,0, 0,0,0, 0,0,0,16384), 1, 0);
        send_query(make_query(131072,0,0,65536, 0,0,0, 0,0,0,16384), 1, 1);
        send_query(make_query(90000,90000,0,30000, 0,0,0, 0,0,11585,11585), 0, 0);
        send_query(make_query(0,0,0,0, 0,0,0, 16384,0,0,0), 0, 0);
        drain();
        set_box(65536, -65536, -65536, -65536, 65536, 65536);
        send_query(make_query(65536,0,0,0, 0,0,0, 0,0,0,16384), 1, 1);
        send_query(make_query(-65536,0,0,0, 0,0,0, 0,0,0,16384), 1, 0);
        drain();

        // Random phases across settings and idling mixes.
        set_box(-100000, -50000, -200000, 100000, 150000, 30000);
        run_random(130);
        drain();
        send_idle_pct = 49;
        set_box(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        run_random(100);
        drain();
        send_idle_pct = 0; recv_stall_pct = 49;
        set_box(32'h7FFFFFFF, 0, -300000, 32'h80000000, 0, 300000);
        run_random(100);
        drain();
        send_idle_pct = 23; recv_stall_pct = 23;
        set_box(-20000, -250000, -65536, 250000, 20000, 65536);
        run_random(100);
        drain();

        // Long receiver hold-off while the sender keeps offering.
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            run_random(60);
        join
        drain();
        write_reg(RegSpare0, 32'h1234_5678);
        write_reg(RegSpare1, 32'hFFFF_FFFF);
        run_random(40);
        drain();

        if (errors == 0 && hit_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/sobo_pkg.sv
hdl/sphere_oriented_box_overlap.sv
tb/sphere_oriented_box_overlap_tb.sv
